// ===== sv/ssr_pkg.sv =====
// Package for the sparse sampled residual unit: sizes, commands, status codes,
// configuration indexes and the stage record shared by the component cells.
// No dependencies.
`default_nettype none
package ssr_pkg;
    localparam int unsigned MaxRows       = 1024;
    localparam int unsigned MaxColumns    = 1024;
    localparam int unsigned MaxComponents = 16;
    localparam int unsigned RowW  = 10;
    localparam int unsigned ColW  = 10;
    localparam int unsigned CompW = 4;
    localparam int unsigned AccW  = 74;
    localparam int unsigned MemDepth = MaxRows * MaxComponents;
    localparam int unsigned AddrW = RowW + CompW;

    typedef enum logic [1:0] {
        t_cmd_write_a = 2'd0,
        t_cmd_write_s = 2'd1,
        t_cmd_entry   = 2'd2,
        t_cmd_unused  = 2'd3
    } t_cmd;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StColOut = 2'd1;
    localparam logic [1:0] StRowOut = 2'd2;
    localparam logic [1:0] StSat    = 2'd3;

    localparam logic [1:0] CfgComponents = 2'd0;
    localparam logic [1:0] CfgRows       = 2'd1;
    localparam logic [1:0] CfgColumns    = 2'd2;

    typedef struct packed {
        logic            busy;
        logic            skip;
        logic [1:0]      status;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic [CompW:0]  ncomp;
        logic [AccW-1:0] acc;
    } t_stage;
endpackage
`default_nettype wire

// ===== sv/sparse_sampled_residual_unit.sv =====
// Top level: command decode, configuration registers, chain of component
// cells, rounding/saturation and output register. Depends on ssr_pkg, ssr_cell.
//
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_ready  | command, row, column, component, value
// out     | output    | o_valid / i_ready  | residual, status
// cfg     | input     | i_cfg_valid/o_cfg_ready | index, data
//
// Entry words can enter the cell chain every cycle; an entry's result passes
// each cell's r_mid and o_stage registers, then the output register. A load
// word waits until no entry is in the chain. The whole chain stalls while the
// output register is full and not taken. Reset clears control, loads the
// maximum configuration; the A and S stores are undefined until written.
`default_nettype none
module sparse_sampled_residual_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_row_index,
    input  wire logic [9:0]  i_column_index,
    input  wire logic [3:0]  i_component_index,
    input  wire logic signed [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_residual,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    import ssr_pkg::*;
    logic [4:0]  r_ncomp;
    logic [10:0] r_nrows, r_ncols;
    logic [5:0]  r_inflight;
    logic        w_adv, w_acc, w_ld, w_done;
    t_stage      w_chain [MaxComponents+1];
    t_stage      w_in;
    logic [AccW-1:0] w_sum;
    logic [AccW-17:0] w_q;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncomp <= 5'd16;
            r_nrows <= 11'd1024;
            r_ncols <= 11'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgComponents: r_ncomp <= i_cfg_data[4:0];
                CfgRows:       r_nrows <= i_cfg_data;
                CfgColumns:    r_ncols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv = !o_valid || i_ready;
    assign w_ld = (i_command == t_cmd_write_a) || (i_command == t_cmd_write_s);
    assign o_ready = w_adv && !(w_ld && (r_inflight != '0));
    assign w_acc = i_valid && o_ready;
    assign w_done = w_adv && w_chain[MaxComponents].busy;

    // entries in the cell chain; loads wait for zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= '0;
        else r_inflight <= r_inflight + 6'(w_in.busy) - 6'(w_done);
    end

    always_comb begin
        w_in.busy = w_acc && (i_command == t_cmd_entry);
        w_in.row = i_row_index;
        w_in.col = i_column_index;
        w_in.ncomp = (r_ncomp > 5'(MaxComponents)) ? 5'(MaxComponents) : r_ncomp;
        w_in.skip = 1'b1;
        w_in.status = StOk;
        if ({1'b0, i_row_index} >= r_nrows) w_in.status = StRowOut;
        else if ({1'b0, i_column_index} >= r_ncols) w_in.status = StColOut;
        else w_in.skip = 1'b0;
        w_in.acc = {{(AccW-48){i_value[31]}}, i_value, 16'd0};
    end
    assign w_chain[0] = w_in;

    for (genvar g = 0; g < MaxComponents; g++) begin : g_cell
        ssr_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_my_comp(CompW'(g)),
            .i_a_we(w_acc && i_command == t_cmd_write_a && i_component_index == CompW'(g)),
            .i_s_we(w_acc && i_command == t_cmd_write_s && i_component_index == CompW'(g)),
            .i_wrow(i_row_index), .i_wcol(i_column_index), .i_wdata(i_value),
            .i_adv(w_adv), .i_stage(w_chain[g]), .o_stage(w_chain[g+1]));
    end

    assign w_sum = w_chain[MaxComponents].acc + AccW'(32768);
    assign w_q = w_sum[AccW-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_adv) o_valid <= w_chain[MaxComponents].busy;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_chain[MaxComponents].skip) begin
                o_residual <= 32'sd0;
                o_status <= w_chain[MaxComponents].status;
            end else if (w_q[AccW-17:31] == '0 || w_q[AccW-17:31] == '1) begin
                o_residual <= w_q[31:0];
                o_status <= StOk;
            end else begin
                o_residual <= w_q[AccW-17] ? 32'sh80000000 : 32'sh7FFFFFFF;
                o_status <= StSat;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/ssr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ssr_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/ssr_cell.sv =====
// One component cell: holds the A and S slices of its component and subtracts
// one product from the passing accumulator. Depends on ssr_pkg, ssr_ram.
`default_nettype none
module ssr_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ssr_pkg::CompW-1:0]   i_my_comp,
    input  wire logic                        i_a_we,
    input  wire logic                        i_s_we,
    input  wire logic [ssr_pkg::RowW-1:0]    i_wrow,
    input  wire logic [ssr_pkg::ColW-1:0]    i_wcol,
    input  wire logic [31:0]                 i_wdata,
    input  wire logic                        i_adv,
    input  wire ssr_pkg::t_stage             i_stage,
    output ssr_pkg::t_stage                  o_stage
);
    import ssr_pkg::*;
    logic [31:0] w_a, w_s;
    logic [RowW-1:0] w_ra;
    logic [ColW-1:0] w_ca;
    logic [63:0] w_prod;
    t_stage r_mid;
    // hold the read address on the waiting word while stalled
    assign w_ra = i_adv ? i_stage.row : r_mid.row;
    assign w_ca = i_adv ? i_stage.col : r_mid.col;
    ssr_ram #(.Width(32), .Depth(MaxRows)) u_a (
        .i_clk(i_clk), .i_we(i_a_we), .i_waddr(i_wrow), .i_wdata(i_wdata),
        .i_raddr(w_ra), .o_rdata(w_a));
    ssr_ram #(.Width(32), .Depth(MaxColumns)) u_s (
        .i_clk(i_clk), .i_we(i_s_we), .i_waddr(i_wcol), .i_wdata(i_wdata),
        .i_raddr(w_ca), .o_rdata(w_s));
    assign w_prod = 64'($signed(w_a) * $signed(w_s));
    // stage 1: memory read; stage 2: multiply and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.busy <= 1'b0;
            o_stage.busy <= 1'b0;
        end else if (i_adv) begin
            r_mid <= i_stage;
            o_stage <= r_mid;
            if (r_mid.busy && !r_mid.skip && ({1'b0, i_my_comp} < r_mid.ncomp))
                o_stage.acc <= r_mid.acc - {{(AccW-64){w_prod[63]}}, w_prod};
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for sparse_sampled_residual_unit: a directed table, then
// random phases under several register settings and idle patterns, checked against
// table values and an in-bench residual predictor. Depends on ssr_pkg and the unit RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ssr_pkg::*;

    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int Limit = 2000000;
    localparam int Settle = 2 * MaxComponents + 8;

    typedef struct packed {
        logic signed [31:0] residual;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        t_cmd               cmd;
        logic [9:0]         row;
        logic [9:0]         col;
        logic [3:0]         comp;
        logic [31:0]        val;
        logic               typed;
        logic signed [31:0] res;
        logic [1:0]         st;
    } dir_row_t;

    localparam dir_row_t Directed[20] = '{
        '{t_cmd_write_a, 10'd0, 10'd0, 4'd0, 32'h0001_0000, 1'b0, 32'd0, StOk},
        '{t_cmd_write_s, 10'd0, 10'd0, 4'd0, 32'h0002_0000, 1'b0, 32'd0, StOk},
        '{t_cmd_entry, 10'd0, 10'd0, 4'd0, 32'h0005_0000, 1'b1, 32'h0003_0000, StOk},
        '{t_cmd_entry, 10'd1021, 10'd0, 4'd15, 32'h1234_5678, 1'b1, 32'd0, StRowOut},
        '{t_cmd_entry, 10'd0, 10'd1023, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, StColOut},
        '{t_cmd_entry, 10'd1023, 10'd1023, 4'd15, 32'h7FFF_FFFF, 1'b1, 32'd0, StRowOut},
        '{t_cmd_write_a, 10'd1, 10'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'd0, StOk},
        '{t_cmd_write_s, 10'd0, 10'd1, 4'd0, 32'h8000_0000, 1'b0, 32'd0, StOk},
        '{t_cmd_entry, 10'd1, 10'd1, 4'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, StSat},
        '{t_cmd_entry, 10'd1, 10'd1, 4'd0, 32'h8000_0000, 1'b0, 32'd0, StOk},
        '{t_cmd_write_a, 10'd2, 10'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'd0, StOk},
        '{t_cmd_write_s, 10'd0, 10'd2, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'd0, StOk},
        '{t_cmd_entry, 10'd2, 10'd2, 4'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, StSat},
        '{t_cmd_write_a, 10'd3, 10'd0, 4'd0, 32'h0000_0001, 1'b0, 32'd0, StOk},
        '{t_cmd_write_s, 10'd0, 10'd3, 4'd0, 32'h0000_8000, 1'b0, 32'd0, StOk},
        '{t_cmd_entry, 10'd3, 10'd3, 4'd0, 32'h0000_0010, 1'b1, 32'h0000_0010, StOk},
        '{t_cmd_unused, 10'd1023, 10'd1023, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0, StOk},
        '{t_cmd_write_a, 10'd1023, 10'd1023, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0, StOk},
        '{t_cmd_write_s, 10'd1023, 10'd1023, 4'd15, 32'h8000_0000, 1'b0, 32'd0, StOk},
        '{t_cmd_entry, 10'd0, 10'd0, 4'd0, 32'h0000_0000, 1'b0, 32'd0, StOk}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [9:0]  i_row_index;
    logic [9:0]  i_column_index;
    logic [3:0]  i_component_index;
    logic signed [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_residual;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    sparse_sampled_residual_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] loading_mem [MemDepth];
    logic signed [31:0] score_mem [MemDepth];
    bit loading_set [MemDepth];
    bit score_set [MemDepth];
    logic [4:0]  comp_reg;
    logic [10:0] rows_reg;
    logic [10:0] cols_reg;
    result_t residual_q[$];

    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int work_set[8] = '{0, 1, 2, 3, 512, 1021, 1022, 1023};

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > Limit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(negedge i_clk) begin
        result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (residual_q.size() == 0) begin
                $error("unexpected word: residual %h status %0d", o_residual, o_status);
                errors++;
            end else begin
                want = residual_q.pop_front();
                if (o_residual !== want.residual) begin
                    $error("residual: expected %h, got %h", want.residual, o_residual);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic int row_limit();
        return (rows_reg < MaxRows) ? int'(rows_reg) : MaxRows;
    endfunction

    function automatic int col_limit();
        return (cols_reg < MaxColumns) ? int'(cols_reg) : MaxColumns;
    endfunction

    function automatic int comp_limit();
        return (comp_reg < MaxComponents) ? int'(comp_reg) : MaxComponents;
    endfunction

    function automatic result_t residual_of(int row, int col, logic signed [31:0] val);
        result_t r;
        logic signed [127:0] acc;
        logic signed [127:0] prod;
        logic signed [127:0] q;
        if (row >= row_limit()) begin
            r = '{32'sd0, StRowOut};
        end else if (col >= col_limit()) begin
            r = '{32'sd0, StColOut};
        end else begin
            acc = val;
            acc = acc <<< 16;
            for (int k = 0; k < comp_limit(); k++) begin
                prod = loading_mem[row * MaxComponents + k];
                prod = prod * score_mem[k * MaxColumns + col];
                acc = acc - prod;
            end
            acc = acc + 128'sd32768;
            q = acc >>> 16;
            if (q[127:31] == {97{q[31]}})
                r = '{q[31:0], StOk};
            else
                r = '{acc[127] ? 32'h8000_0000 : 32'h7FFF_FFFF, StSat};
        end
        return r;
    endfunction

    function automatic bit reads_unwritten(int row, int col);
        if (row >= row_limit() || col >= col_limit()) return 1'b0;
        for (int k = 0; k < comp_limit(); k++)
            if (!loading_set[row * MaxComponents + k] || !score_set[k * MaxColumns + col])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed(18'($urandom)));
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(1) ? 32'h0001_0000 + $urandom_range(255)
                                              : 32'hFFFF_0000 - $urandom_range(255);
        endcase
    endfunction

    task automatic push(t_cmd cmd, logic [9:0] row, logic [9:0] col, logic [3:0] comp,
                        logic [31:0] val, bit typed, result_t want);
        bit got;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_row_index <= row;
        i_column_index <= col;
        i_component_index <= comp;
        i_value <= val;
        do begin
            @(negedge i_clk);
            got = o_ready;
            @(posedge i_clk);
        end while (!got);
        case (cmd)
            t_cmd_write_a: begin
                loading_mem[row * MaxComponents + comp] = val;
                loading_set[row * MaxComponents + comp] = 1'b1;
            end
            t_cmd_write_s: begin
                score_mem[comp * MaxColumns + col] = val;
                score_set[comp * MaxColumns + col] = 1'b1;
            end
            t_cmd_entry: residual_q.push_back(typed ? want : residual_of(row, col, val));
            default: ;
        endcase
    endtask

    task automatic wait_empty();
        i_valid <= 1'b0;
        while (residual_q.size() != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [10:0] data);
        bit got;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            got = o_cfg_ready;
            @(posedge i_clk);
        end while (!got);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgComponents: comp_reg = data[4:0];
            CfgRows:       rows_reg = data;
            CfgColumns:    cols_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(int ncomp, int nrows, int ncols);
        cfg_write(CfgComponents, {6'($urandom), 5'(ncomp)});
        cfg_write(CfgRows, 11'(nrows));
        cfg_write(CfgColumns, 11'(ncols));
    endtask

    task automatic pick_index(int lim, output int idx);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: idx = work_set[$urandom_range(7)];
            6: idx = (lim < 1024) ? lim : 1023;
            7: idx = (lim > 0) ? lim - 1 : 0;
            default: idx = $urandom_range(1023);
        endcase
    endtask

    task automatic random_items(int n);
        int row;
        int col;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick_index(row_limit(), row);
                pick_index(col_limit(), col);
                if (reads_unwritten(row, col)) begin
                    row = work_set[$urandom_range(7)];
                    col = work_set[$urandom_range(7)];
                end
                push(t_cmd_entry, 10'(row), 10'(col), 4'($urandom), rand_value(), 1'b0, '0);
            end else if (pick < 95) begin
                row = $urandom_range(1) ? work_set[$urandom_range(7)] : $urandom_range(1023);
                col = $urandom_range(1) ? work_set[$urandom_range(7)] : $urandom_range(1023);
                push(pick < 70 ? t_cmd_write_a : t_cmd_write_s, 10'(row), 10'(col),
                     4'($urandom), rand_value(), 1'b0, '0);
            end else begin
                push(t_cmd_unused, 10'($urandom), 10'($urandom), 4'($urandom), $urandom,
                     1'b0, '0);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= t_cmd_write_a;
        i_row_index <= '0;
        i_column_index <= '0;
        i_component_index <= '0;
        i_value <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CfgComponents;
        i_cfg_data <= '0;
        comp_reg = 5'd16;
        rows_reg = 11'd1024;
        cols_reg = 11'd1024;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the working rows and columns so every entry there reads written words
        foreach (work_set[w])
            for (int k = 0; k < MaxComponents; k++) begin
                push(t_cmd_write_a, 10'(work_set[w]), 10'($urandom), 4'(k), rand_value(),
                     1'b0, '0);
                push(t_cmd_write_s, 10'($urandom), 10'(work_set[w]), 4'(k), rand_value(),
                     1'b0, '0);
            end
        wait_empty();

        configure(1, 1000, 1000);
        foreach (Directed[d])
            push(Directed[d].cmd, Directed[d].row, Directed[d].col, Directed[d].comp,
                 Directed[d].val, Directed[d].typed, '{Directed[d].res, Directed[d].st});
        wait_empty();

        configure(16, 1024, 1024);
        random_items(250);
        wait_empty();

        configure(31, 2047, 2047);
        send_idle = 77;
        random_items(250);
        wait_empty();

        cfg_write(CfgUnused, 11'h7FF);
        configure(5, 600, 700);
        send_idle = 0;
        recv_stall = 77;
        random_items(100);
        hold_left = 300;
        random_items(150);
        wait_empty();

        configure(0, 1, 1);
        send_idle = 15;
        recv_stall = 15;
        random_items(200);
        wait_empty();

        configure(1, 0, 0);
        send_idle = 0;
        recv_stall = 0;
        random_items(100);
        wait_empty();

        configure($urandom_range(1, 16), $urandom_range(1, 1024), $urandom_range(1, 1024));
        send_idle = 15;
        recv_stall = 15;
        random_items(200);
        wait_empty();
        random_items(200);
        wait_empty();

        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/ssr_pkg.sv
sv/ssr_ram.sv
sv/ssr_cell.sv
sv/sparse_sampled_residual_unit.sv
tb/tb_top.sv
